// ===== src/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// shared types and codes of the cuckoo hash table
// ----------------------------------------------------------------------------
`default_nettype none
package cht_pkg;
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FAILED  = 2'd2;

    localparam logic [0:0] CFG_KICKS  = 1'b0;
    localparam logic [0:0] CFG_MULT   = 1'b1;

    localparam logic [6:0]  KICKS_RESET = 7'd10;
    localparam logic [63:0] MULT_RESET  = 64'd11400714819323198485;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key;
        logic [63:0] payload;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_payload;
        logic [63:0] homeless_key;
        logic [63:0] homeless_payload;
    } t_rsp;

    // multiplier control between sequencer and unit
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;
endpackage
`default_nettype wire

// ===== src/cht_if.sv =====
// ----------------------------------------------------------------------------
// cht_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
`default_nettype none
interface cht_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/cht_ram.sv =====
// ----------------------------------------------------------------------------
// cht_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== src/cht_mul.sv =====
// ----------------------------------------------------------------------------
// cht_mul
// 64x64 low-half multiplier, three 32x32 partial products through one multiplier
// ----------------------------------------------------------------------------
`default_nettype none
module cht_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cht_pkg::t_mul_req i_req,
    output logic                   o_done,
    output logic [63:0]            o_prod
);
    logic [2:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [63:0] r_pp;
    logic [31:0] w_x;
    logic [31:0] w_y;
    logic [63:0] w_pp;

    // partial product select: lo*lo, lo*hi, hi*lo
    always_comb begin
        case (r_step)
            3'd2:    begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            3'd3:    begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            default: begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
        endcase
    end

    // the one shared 32x32 product
    assign w_pp = {32'd0, w_x} * {32'd0, w_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_req.start && (r_step == 3'd4);
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= 64'd0;
                r_step <= 3'd1;
            end else if (r_step != 3'd0) begin
                // registered multiply, then accumulate next cycle
                case (r_step)
                    3'd1: begin
                        r_pp   <= w_pp;
                        r_step <= 3'd2;
                    end
                    3'd2: begin
                        r_acc  <= r_pp;
                        r_pp   <= w_pp;
                        r_step <= 3'd3;
                    end
                    3'd3: begin
                        r_acc  <= r_acc + {r_pp[31:0], 32'd0};
                        r_pp   <= w_pp;
                        r_step <= 3'd4;
                    end
                    default: begin
                        o_prod <= r_acc + {r_pp[31:0], 32'd0};
                        r_step <= 3'd0;
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/cuckoo_hash_table.sv =====
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// two-table cuckoo hash map of 64-bit keys and payloads
// ----------------------------------------------------------------------------
// usage: requests come in on i_req (insert, lookup, delete) and one response
// word per request leaves on o_rsp. the block takes one request at a time:
// i_req.ready is high only while the sequencer is idle and the response
// register is empty.
// every hash goes through one shared multiplier (three 32x32 partial-product
// steps) that yields the slot numbers; a probe reads a slot, then checks it.
// lookup and delete: table one is probed first, and table two only when
// table one misses; both use the slot numbers of one hash.
// insert: each table probe follows a hash of the carried key; the entry is
// placed in table one or table two, or the request fails after max_kicks
// rounds with the last displaced entry homeless; zero max_kicks fails unprobed.
// an unused request type answers with a miss without probing.
// reset: a clearing pass over all TABLE_DEPTH slots empties both tables with
// i_req.ready low; max_kicks returns to 10 and the multiplier to its default.
// stall: a response held by the receiver blocks the next request; nothing
// is lost. configuration is to be written through i_cfg_we / i_cfg_idx /
// i_cfg_data only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none
module cuckoo_hash_table #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    cht_if.sink              i_req,
    cht_if.source            o_rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HASH  = 4'd1;
    localparam logic [3:0] S_WAITM = 4'd2;
    localparam logic [3:0] S_RD1   = 4'd3;
    localparam logic [3:0] S_CHK1  = 4'd4;
    localparam logic [3:0] S_RD2   = 4'd5;
    localparam logic [3:0] S_CHK2  = 4'd6;
    localparam logic [3:0] S_RESP  = 4'd7;
    localparam logic [3:0] S_CLEAR = 4'd8;

    logic [3:0]  r_state;
    logic [6:0]  r_kicks;
    logic [63:0] r_mult;
    logic [1:0]  r_req;
    logic [63:0] r_key;
    logic [63:0] r_pay;
    logic [6:0]  r_round;
    logic        r_tbl;
    logic [AW-1:0] r_p1;
    logic [AW-1:0] r_p2;
    logic [AW-1:0] r_clr;
    logic        r_ovalid;
    cht_pkg::t_rsp r_rsp;

    cht_pkg::t_mul_req w_mreq;
    logic        w_mdone;
    logic [63:0] w_prod;

    // table ports: one ram per table holds valid, key and payload
    logic            w_we1, w_we2;
    logic [AW-1:0]   w_a1, w_a2;
    logic [128:0]    w_wd, w_rd1, w_rd2;
    logic            w_clr;
    logic            w_hit1, w_hit2;

    cht_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mreq),
        .o_done (w_mdone),
        .o_prod (w_prod)
    );

    cht_ram #(.WIDTH(129), .DEPTH(TABLE_DEPTH)) u_t1 (
        .i_clk(i_clk), .i_we(w_we1), .i_addr(w_a1), .i_wdata(w_wd), .o_rdata(w_rd1)
    );
    cht_ram #(.WIDTH(129), .DEPTH(TABLE_DEPTH)) u_t2 (
        .i_clk(i_clk), .i_we(w_we2), .i_addr(w_a2), .i_wdata(w_wd), .o_rdata(w_rd2)
    );

    assign w_mreq.start = (r_state == S_HASH);
    assign w_mreq.a     = r_key;
    assign w_mreq.b     = r_mult;

    // clearing pass walks every slot after reset
    assign w_clr = (r_state == S_CLEAR);
    assign w_a1  = w_clr ? r_clr : r_p1;
    assign w_a2  = w_clr ? r_clr : r_p2;
    // insert writes the carried entry as valid, delete writes it back invalid
    assign w_wd  = w_clr ? '0 : {(r_req == cht_pkg::REQ_INSERT), r_key, r_pay};

    assign w_hit1 = w_rd1[128] && (w_rd1[127:64] == r_key);
    assign w_hit2 = w_rd2[128] && (w_rd2[127:64] == r_key);

    assign w_we1 = w_clr || ((r_state == S_CHK1) &&
                   ((r_req == cht_pkg::REQ_INSERT) ||
                    ((r_req == cht_pkg::REQ_DELETE) && w_hit1)));
    assign w_we2 = w_clr || ((r_state == S_CHK2) &&
                   ((r_req == cht_pkg::REQ_INSERT) ||
                    ((r_req == cht_pkg::REQ_DELETE) && w_hit2)));

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_kicks  <= cht_pkg::KICKS_RESET;
            r_mult   <= cht_pkg::MULT_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cht_pkg::CFG_KICKS: r_kicks <= i_cfg_data[6:0];
                    default:            r_mult  <= i_cfg_data;
                endcase
            end
            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req   <= i_req.data.req_type;
                        r_key   <= i_req.data.key;
                        r_pay   <= i_req.data.payload;
                        r_round <= 7'd0;
                        r_tbl   <= 1'b0;
                        if ((i_req.data.req_type == cht_pkg::REQ_INSERT) &&
                            (r_kicks == 7'd0)) begin
                            r_rsp <= '{status:           cht_pkg::ST_FAILED,
                                       found_payload:    64'd0,
                                       homeless_key:     i_req.data.key,
                                       homeless_payload: i_req.data.payload};
                            r_state <= S_RESP;
                        end else begin
                            r_rsp <= '{status:           cht_pkg::ST_MISS,
                                       found_payload:    64'd0,
                                       homeless_key:     64'd0,
                                       homeless_payload: 64'd0};
                            if (i_req.data.req_type inside {cht_pkg::REQ_INSERT,
                                    cht_pkg::REQ_LOOKUP, cht_pkg::REQ_DELETE}) begin
                                r_state <= S_HASH;
                            end else begin
                                r_state <= S_RESP;
                            end
                        end
                    end
                end
                S_HASH:  r_state <= S_WAITM;
                S_WAITM: begin
                    if (w_mdone) begin
                        r_p1 <= w_prod[AW-1:0];
                        r_p2 <= w_prod[2*AW-1:AW];
                        r_state <= r_tbl ? S_RD2 : S_RD1;
                    end
                end
                S_RD1: r_state <= S_CHK1;
                S_CHK1: begin
                    if (r_req == cht_pkg::REQ_INSERT) begin
                        if (!w_rd1[128]) begin
                            r_rsp.status <= cht_pkg::ST_DONE;
                            r_state <= S_RESP;
                        end else begin
                            // carry the displaced entry on to table two
                            r_key <= w_rd1[127:64];
                            r_pay <= w_rd1[63:0];
                            r_tbl <= 1'b1;
                            r_state <= S_HASH;
                        end
                    end else if (w_hit1) begin
                        r_rsp <= '{status:           cht_pkg::ST_DONE,
                                   found_payload:    (r_req == cht_pkg::REQ_LOOKUP) ?
                                                     w_rd1[63:0] : 64'd0,
                                   homeless_key:     64'd0,
                                   homeless_payload: 64'd0};
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_RD2;
                    end
                end
                S_RD2: r_state <= S_CHK2;
                S_CHK2: begin
                    if (r_req == cht_pkg::REQ_INSERT) begin
                        if (!w_rd2[128]) begin
                            r_rsp.status <= cht_pkg::ST_DONE;
                            r_state <= S_RESP;
                        end else begin
                            r_key <= w_rd2[127:64];
                            r_pay <= w_rd2[63:0];
                            r_tbl <= 1'b0;
                            if (r_round + 7'd1 >= r_kicks) begin
                                r_rsp <= '{status:           cht_pkg::ST_FAILED,
                                           found_payload:    64'd0,
                                           homeless_key:     w_rd2[127:64],
                                           homeless_payload: w_rd2[63:0]};
                                r_state <= S_RESP;
                            end else begin
                                r_round <= r_round + 7'd1;
                                r_state <= S_HASH;
                            end
                        end
                    end else begin
                        if (w_hit2) begin
                            r_rsp <= '{status:           cht_pkg::ST_DONE,
                                       found_payload:    (r_req == cht_pkg::REQ_LOOKUP) ?
                                                         w_rd2[63:0] : 64'd0,
                                       homeless_key:     64'd0,
                                       homeless_payload: 64'd0};
                        end
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // a response is only raised out of the response state
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_RESP)
        else $error("response without finishing a request");
    // no request is taken while a response waits
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !i_req.ready)
        else $error("request accepted with response pending");
    // the kick counter never runs past the limit
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_CLEAR &&
         r_req == cht_pkg::REQ_INSERT && r_kicks != 7'd0)
        |-> r_round < r_kicks)
        else $error("kick round overran");
`endif
endmodule
`default_nettype wire
